/* rtl/ethernet_ipv4_header_parser_assert.svh */
// Assertion macros used by the checker file.
`ifndef ETHERNET_IPV4_HEADER_PARSER_ASSERT_SVH
`define ETHERNET_IPV4_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ETHIP_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("ethip assertion failed");

// Next-cycle implication, disabled while in reset.
`define ETHIP_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("ethip assertion failed");

`endif

/* rtl/ethip_pkg.sv */
package ethip_pkg;

  localparam int POS_W         = 17;
  localparam int BYTE_W        = 8;
  localparam int MAC_W         = 48;
  localparam int IP_W          = 32;
  localparam int PORT_W        = 16;
  localparam int LEN_W         = 16;
  localparam int FLEN_W        = 17;
  localparam int CLASS_W       = 2;
  localparam int OUT_COUNT_W   = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [BYTE_W-1:0] PROTO_TCP = 8'd6;
  localparam logic [BYTE_W-1:0] PROTO_UDP = 8'd17;

  // byte offsets within a frame
  localparam logic [POS_W-1:0] OFS_SRC_MAC  = 17'd6;
  localparam logic [POS_W-1:0] OFS_TYPE     = 17'd12;
  localparam logic [POS_W-1:0] OFS_LEN_HI   = 17'd16;
  localparam logic [POS_W-1:0] OFS_LEN_LO   = 17'd17;
  localparam logic [POS_W-1:0] OFS_PROTO    = 17'd23;
  localparam logic [POS_W-1:0] OFS_SRC_IP   = 17'd26;
  localparam logic [POS_W-1:0] OFS_DST_IP   = 17'd30;
  localparam logic [POS_W-1:0] OFS_SRC_PORT = 17'd34;
  localparam logic [POS_W-1:0] OFS_DST_PORT = 17'd36;

  localparam logic [POS_W-1:0]  HDR_NO_PORTS   = 17'd34;
  localparam logic [POS_W-1:0]  HDR_WITH_PORTS = 17'd38;
  localparam logic [FLEN_W-1:0] ETH_HDR_BYTES  = 17'd14;

  localparam logic [CLASS_W-1:0] CLASS_TCP   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_UDP   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd3;

  typedef struct packed {
    logic [MAC_W-1:0]       dest_mac;
    logic [MAC_W-1:0]       source_mac;
    logic [CLASS_W-1:0]     proto_class;
    logic [IP_W-1:0]        source_ip;
    logic [IP_W-1:0]        dest_ip;
    logic [PORT_W-1:0]      source_port;
    logic [PORT_W-1:0]      dest_port;
    logic [FLEN_W-1:0]      frame_length;
    logic [OUT_COUNT_W-1:0] packet_number;
    logic [OUT_COUNT_W-1:0] tcp_total;
    logic [OUT_COUNT_W-1:0] udp_total;
  } res_t;

endpackage

/* rtl/ethip_if.sv */
interface ethip_in_if import ethip_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ethip_out_if import ethip_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [MAC_W-1:0]       dest_mac;
  logic [MAC_W-1:0]       source_mac;
  logic [CLASS_W-1:0]     proto_class;
  logic [IP_W-1:0]        source_ip;
  logic [IP_W-1:0]        dest_ip;
  logic [PORT_W-1:0]      source_port;
  logic [PORT_W-1:0]      dest_port;
  logic [FLEN_W-1:0]      frame_length;
  logic [OUT_COUNT_W-1:0] packet_number;
  logic [OUT_COUNT_W-1:0] tcp_total;
  logic [OUT_COUNT_W-1:0] udp_total;

  modport source (
    output valid, output dest_mac, output source_mac, output proto_class,
    output source_ip, output dest_ip, output source_port, output dest_port,
    output frame_length, output packet_number, output tcp_total, output udp_total,
    input ready
  );
  modport sink (
    input valid, input dest_mac, input source_mac, input proto_class,
    input source_ip, input dest_ip, input source_port, input dest_port,
    input frame_length, input packet_number, input tcp_total, input udp_total,
    output ready
  );
endinterface

/* rtl/ethernet_ipv4_header_parser.sv */
// Channel  | Dir | Handshake     | Payload
// ---------+-----+---------------+-----------------------------------------
// in_ch    | in  | valid/ready   | data_byte, one byte of the frame stream
// out_ch   | out | valid/ready   | header fields, class, running counts
//
// One byte per cycle while in_ch.ready is high; a byte is parsed in the cycle it transfers.
// A frame's result is registered into out_r, or into the skid entry if out_r is stalled.
// An output register plus one skid entry let input keep flowing while a
// result waits; in_ch.ready drops only when both are occupied.
// rst_n is synchronous: clears byte position, captured fields, counts and
// output valids.
module ethernet_ipv4_header_parser
  import ethip_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ethip_in_if.sink    in_ch,
  ethip_out_if.source out_ch
);

  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [MAC_W-1:0]       dmac_r, dmac_nxt;
  logic [MAC_W-1:0]       smac_r, smac_nxt;
  logic [LEN_W-1:0]       iplen_r, iplen_nxt;
  logic [BYTE_W-1:0]      proto_r, proto_nxt;
  logic [IP_W-1:0]        sip_r, sip_nxt;
  logic [IP_W-1:0]        dip_r, dip_nxt;
  logic [PORT_W-1:0]      sport_r, sport_nxt;
  logic [PORT_W-1:0]      dport_r, dport_nxt;
  logic [COUNT_WIDTH-1:0] pkt_cnt_r, pkt_cnt_nxt;
  logic [COUNT_WIDTH-1:0] tcp_cnt_r, tcp_cnt_nxt;
  logic [COUNT_WIDTH-1:0] udp_cnt_r, udp_cnt_nxt;

  res_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;

  logic [BYTE_W-1:0] b;
  logic              in_fire, out_fire, last, emit;
  logic              is_tcp, is_udp, ported;
  logic [POS_W-1:0]  hdr_len, end_pos;
  logic [FLEN_W-1:0] flen;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  assign b        = in_ch.data_byte;
  assign in_ch.ready = !skid_valid_r;
  assign in_fire  = in_ch.valid && !skid_valid_r;
  assign out_fire = out_valid_r && out_ch.ready;

  always_comb begin
    dmac_nxt  = dmac_r;
    smac_nxt  = smac_r;
    iplen_nxt = iplen_r;
    proto_nxt = proto_r;
    sip_nxt   = sip_r;
    dip_nxt   = dip_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;

    if (pos_r < OFS_SRC_MAC) begin
      dmac_nxt = {dmac_r[MAC_W-BYTE_W-1:0], b};
    end else if (pos_r < OFS_TYPE) begin
      smac_nxt = {smac_r[MAC_W-BYTE_W-1:0], b};
    end else if (pos_r == OFS_LEN_HI || pos_r == OFS_LEN_LO) begin
      iplen_nxt = {iplen_r[LEN_W-BYTE_W-1:0], b};
    end else if (pos_r == OFS_PROTO) begin
      proto_nxt = b;
    end else if (pos_r >= OFS_SRC_IP && pos_r < OFS_DST_IP) begin
      sip_nxt = {sip_r[IP_W-BYTE_W-1:0], b};
    end else if (pos_r >= OFS_DST_IP && pos_r < OFS_SRC_PORT) begin
      dip_nxt = {dip_r[IP_W-BYTE_W-1:0], b};
    end

    // protocol seen this byte already counts
    is_tcp = (proto_nxt == PROTO_TCP);
    is_udp = (proto_nxt == PROTO_UDP);
    ported = is_tcp || is_udp;

    if (ported && pos_r >= OFS_SRC_PORT && pos_r < OFS_DST_PORT) begin
      sport_nxt = {sport_r[PORT_W-BYTE_W-1:0], b};
    end else if (ported && pos_r >= OFS_DST_PORT && pos_r < HDR_WITH_PORTS) begin
      dport_nxt = {dport_r[PORT_W-BYTE_W-1:0], b};
    end

    // frame ends at total length + 14, never inside the headers
    hdr_len = ported ? HDR_WITH_PORTS : HDR_NO_PORTS;
    flen    = {1'b0, iplen_nxt} + ETH_HDR_BYTES;
    end_pos = (flen > hdr_len) ? flen : hdr_len;
    last    = ({1'b0, pos_r} + 18'd1) >= {1'b0, end_pos};
    pos_nxt = last ? '0 : pos_r + POS_W'(1);

    pkt_cnt_nxt = sat_inc(pkt_cnt_r);
    tcp_cnt_nxt = is_tcp ? sat_inc(tcp_cnt_r) : tcp_cnt_r;
    udp_cnt_nxt = is_udp ? sat_inc(udp_cnt_r) : udp_cnt_r;

    res.dest_mac      = dmac_nxt;
    res.source_mac    = smac_nxt;
    res.proto_class   = is_tcp ? CLASS_TCP : (is_udp ? CLASS_UDP : CLASS_OTHER);
    res.source_ip     = sip_nxt;
    res.dest_ip       = dip_nxt;
    res.source_port   = ported ? sport_nxt : '0;
    res.dest_port     = ported ? dport_nxt : '0;
    res.frame_length  = flen;
    res.packet_number = OUT_COUNT_W'(pkt_cnt_nxt);
    res.tcp_total     = OUT_COUNT_W'(tcp_cnt_nxt);
    res.udp_total     = OUT_COUNT_W'(udp_cnt_nxt);
  end

  assign emit = in_fire && last;

  // capture registers, loaded as header bytes go by
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmac_r  <= '0;
      smac_r  <= '0;
      iplen_r <= '0;
      proto_r <= '0;
      sip_r   <= '0;
      dip_r   <= '0;
      sport_r <= '0;
      dport_r <= '0;
    end else if (in_fire) begin
      dmac_r  <= dmac_nxt;
      smac_r  <= smac_nxt;
      iplen_r <= iplen_nxt;
      proto_r <= proto_nxt;
      sip_r   <= sip_nxt;
      dip_r   <= dip_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      pkt_cnt_r <= '0;
      tcp_cnt_r <= '0;
      udp_cnt_r <= '0;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
      if (last) begin
        pkt_cnt_r <= pkt_cnt_nxt;
        tcp_cnt_r <= tcp_cnt_nxt;
        udp_cnt_r <= udp_cnt_nxt;
      end
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (emit) begin
      if (!out_valid_r || out_fire) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.dest_mac      = out_r.dest_mac;
  assign out_ch.source_mac    = out_r.source_mac;
  assign out_ch.proto_class   = out_r.proto_class;
  assign out_ch.source_ip     = out_r.source_ip;
  assign out_ch.dest_ip       = out_r.dest_ip;
  assign out_ch.source_port   = out_r.source_port;
  assign out_ch.dest_port     = out_r.dest_port;
  assign out_ch.frame_length  = out_r.frame_length;
  assign out_ch.packet_number = out_r.packet_number;
  assign out_ch.tcp_total     = out_r.tcp_total;
  assign out_ch.udp_total     = out_r.udp_total;

endmodule

/* rtl/ethip_chk.sv */
`include "ethernet_ipv4_header_parser_assert.svh"

module ethip_chk
  import ethip_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [MAC_W-1:0]       dest_mac,
  input logic [CLASS_W-1:0]     proto_class,
  input logic [PORT_W-1:0]      source_port,
  input logic [PORT_W-1:0]      dest_port,
  input logic [FLEN_W-1:0]      frame_length,
  input logic [OUT_COUNT_W-1:0] packet_number
);

  // a stalled result holds
  `ETHIP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(dest_mac) && $stable(packet_number) && $stable(frame_length))

  `ETHIP_ASSERT_NOW(a_class_code, clk, rst_n, out_valid, proto_class != CLASS_NONE)

  // ports only reported for TCP and UDP
  `ETHIP_ASSERT_NOW(a_other_no_ports, clk, rst_n, out_valid && proto_class == CLASS_OTHER,
    source_port == '0 && dest_port == '0)

  `ETHIP_ASSERT_NOW(a_min_length, clk, rst_n, out_valid, frame_length >= ETH_HDR_BYTES)

endmodule

bind ethernet_ipv4_header_parser ethip_chk u_ethip_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .dest_mac      (out_ch.dest_mac),
  .proto_class   (out_ch.proto_class),
  .source_port   (out_ch.source_port),
  .dest_port     (out_ch.dest_port),
  .frame_length  (out_ch.frame_length),
  .packet_number (out_ch.packet_number)
);
